// ===== src/chtd_pkg.sv =====
// ----------------------------------------------------------------------------
// chtd_pkg
// Shared types, codes and helpers of the canonical Huffman table decoder.
// ----------------------------------------------------------------------------
package chtd_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [8:0]  symbol_index;
      logic [3:0]  code_length;
      logic [14:0] bit_window;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [8:0] symbol;
      logic [3:0] bits_used;
   } rsp_type;

   // one lookup table entry: code length (or longest code length under a root prefix) and value
   typedef struct packed {
      logic [4:0]  len;
      logic [15:0] val;
   } entry_type;

   // verdict on one table entry during a decode
   typedef struct packed {
      logic        bad;
      logic        chain;
      logic [16:0] idx2;
   } lookup_type;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_BUILD  = 2'd1;
   localparam logic [1:0] MODE_DECODE = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_TREE   = 2'd1;
   localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd2;

   localparam logic [4:0]  EMPTY_LEN   = 5'd16;
   localparam logic [15:0] NO_SYMBOL   = 16'hFFFF;
   localparam int          SIZE_W      = 17;
   localparam logic [8:0]  COUNT_RESET = 9'd288;

   // reverse the low n bits of v
   function automatic logic [15:0] rev_bits(input logic [15:0] v, input logic [4:0] n);
      logic [15:0] r;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         if (k < int'(n)) r[k] = v[4'(int'(n) - 1 - k)];
      end
      return r;
   endfunction

endpackage

// ===== src/canonical_huffman_table_decoder.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_table_decoder
// DEFLATE-style canonical Huffman decoder with a two-level lookup table.
// ----------------------------------------------------------------------------
// Load: a new item every cycle; result in the cycle after the transfer.
// Decode: the root entry, then for a long code a sub-table entry, both read through the
//   one registered read port of the table memory.
// Build: sweep of table and prefix memory, length histogram, Kraft sum and first codes,
//   code assignment, root pointers and table size, table fill, then the unused entries.
// Reset: control cleared, symbol_count 288, table not ready; no stall from the receiver.
module canonical_huffman_table_decoder #(
   parameter int ROOT_BITS       = 9,
   parameter int MAX_CODE_LENGTH = 15,
   parameter int MAX_SYMBOLS     = 288,
   parameter int TABLE_DEPTH     = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  chtd_pkg::req_type req_data,
   output logic              rsp_valid,
   output chtd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [8:0]        csr_wdata
);

   localparam int HEAD  = 1 << ROOT_BITS;
   localparam int LAW   = $clog2(MAX_SYMBOLS);
   localparam int TAW   = $clog2(TABLE_DEPTH);
   localparam int HB    = ROOT_BITS;
   localparam int LIMIT = (HEAD > TABLE_DEPTH) ? HEAD : TABLE_DEPTH;
   localparam int CW    = $clog2(LIMIT + 1);
   localparam int HW    = $clog2(MAX_SYMBOLS + 1);
   localparam int KW    = HW + MAX_CODE_LENGTH + 4;
   localparam int SW    = chtd_pkg::SIZE_W;
   localparam logic [CW-1:0] CLR_LAST   = CW'(LIMIT - 1);
   localparam logic [KW-1:0] KRAFT_FULL = KW'(1) << MAX_CODE_LENGTH;

   // one-hot sequencer
   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_CLR      = 16'h0002,  // sweep table and prefix memory
      ST_CNT      = 16'h0004,  // length histogram
      ST_KRF      = 16'h0008,  // Kraft sum and first codes per length
      ST_ASG_RD   = 16'h0010,
      ST_ASG_LEN  = 16'h0020,  // give a symbol its code
      ST_ASG_PFX  = 16'h0040,  // longest code under a root prefix
      ST_SIZ      = 16'h0080,  // root pointers and table size
      ST_FIL_RD   = 16'h0100,
      ST_FIL_SYM  = 16'h0200,
      ST_FIL_ROOT = 16'h0400,
      ST_FIL_EA   = 16'h0800,
      ST_FIL_EW   = 16'h1000,
      ST_FIN      = 16'h2000,  // unused entries
      ST_DEC_R    = 16'h4000,
      ST_DEC_S    = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]  idx_ff, idx_in, prev_ff, prev_in;
   logic           pv_ff, pv_in;
   logic [15:0]    j_ff, j_in;
   logic [3:0]     len_ff, len_in;
   logic [15:0]    rc_ff, rc_in;
   logic [4:0]     maxl_ff, maxl_in;
   logic [15:0]    start_ff, start_in;
   logic [TAW-1:0] ea_ff, ea_in;
   logic [SW-1:0]  size_ff, size_in;
   logic [KW-1:0]  kraft_ff, kraft_in;
   logic [HW-1:0]  present_ff, present_in;
   logic           multi_ff, multi_in;
   logic [15:0]    nc_run_ff, nc_run_in;
   logic [HW-1:0]  hprev_ff, hprev_in;
   logic [14:0]    win_ff, win_in;
   logic           ready_ff, ready_in;
   logic [8:0]     csr_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   chtd_pkg::rsp_type rsp_ff, rsp_in;

   logic [HW-1:0] hist_ff [16];
   logic [15:0]   nc_ff [16];

   // memories
   logic [3:0]                 len_mem [MAX_SYMBOLS];
   logic [MAX_CODE_LENGTH-1:0] rc_mem  [MAX_SYMBOLS];
   logic [3:0]                 pfx_mem [HEAD];
   chtd_pkg::entry_type        tbl_mem [TABLE_DEPTH];

   logic [3:0]                 len_q;
   logic [MAX_CODE_LENGTH-1:0] rc_q;
   logic [3:0]                 pfx_q;
   chtd_pkg::entry_type        tbl_q;

   logic           len_we, rc_we, pfx_we, tbl_we;
   logic [LAW-1:0] len_waddr;
   logic [3:0]     len_wdata, pfx_wdata;
   logic [HB-1:0]  pfx_waddr, pfx_raddr;
   logic [TAW-1:0] tbl_waddr, tbl_raddr;
   chtd_pkg::entry_type tbl_wdata;

   logic          hist_we, hist_clr, nc_we, nc_clr;
   logic [3:0]    hist_wa, nc_wa;
   logic [HW-1:0] hist_wd;
   logic [15:0]   nc_wd;

   // datapath
   logic               accept;
   logic [CW-1:0]      n_cnt;
   logic [3:0]         krf_l;
   logic [KW-1:0]      kraft_sum;
   logic [HW-1:0]      present_sum;
   logic [15:0]        nc_gen, code_a, rev_a;
   logic [SW-1:0]      ea_short, ea_long;
   logic               short_code, j_last;
   chtd_pkg::lookup_type ev;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // symbol count saturates at the store depth
   assign n_cnt = (CW'(csr_ff) > CW'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : CW'(csr_ff);

   assign krf_l       = idx_ff[3:0];
   assign kraft_sum   = kraft_ff + (KW'(hist_ff[krf_l]) << (4'(MAX_CODE_LENGTH) - krf_l));
   assign present_sum = present_ff + hist_ff[krf_l];
   assign nc_gen      = 16'((nc_run_ff + 16'(hprev_ff)) << 1);

   assign code_a = nc_ff[len_q] & ((16'd1 << len_q) - 16'd1);
   assign rev_a  = chtd_pkg::rev_bits(code_a, {1'b0, len_q});

   assign short_code = ({1'b0, len_ff} <= 5'(ROOT_BITS));
   assign ea_short   = SW'(rc_ff) | (SW'(j_ff) << len_ff);
   assign ea_long    = SW'(start_ff) + ((SW'(rc_ff) >> ROOT_BITS)
                       | (SW'(j_ff) << (len_ff - 4'(ROOT_BITS))));
   assign j_last     = short_code
                       ? (j_ff == (16'd1 << (4'(ROOT_BITS) - len_ff)) - 16'd1)
                       : (j_ff == (16'd1 << (maxl_ff - {1'b0, len_ff})) - 16'd1);

   chtd_lookup #(
      .ROOT_BITS       (ROOT_BITS),
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .MAX_SYMBOLS     (MAX_SYMBOLS),
      .TABLE_DEPTH     (TABLE_DEPTH)
   ) u_lookup (
      .entry  (tbl_q),
      .window (win_ff),
      .second (state_ff == ST_DEC_S),
      .result (ev)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      pv_in        = 1'b0;
      j_in         = j_ff;
      len_in       = len_ff;
      rc_in        = rc_ff;
      maxl_in      = maxl_ff;
      start_in     = start_ff;
      ea_in        = ea_ff;
      size_in      = size_ff;
      kraft_in     = kraft_ff;
      present_in   = present_ff;
      multi_in     = multi_ff;
      nc_run_in    = nc_run_ff;
      hprev_in     = hprev_ff;
      win_in       = win_ff;
      ready_in     = ready_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      len_we    = 1'b0;
      len_waddr = LAW'(req_data.symbol_index);
      len_wdata = req_data.code_length;
      rc_we     = 1'b0;
      pfx_we    = 1'b0;
      pfx_waddr = idx_ff[HB-1:0];
      pfx_wdata = 4'd0;
      pfx_raddr = idx_ff[HB-1:0];
      tbl_we    = 1'b0;
      tbl_waddr = idx_ff[TAW-1:0];
      tbl_wdata = '{len: chtd_pkg::EMPTY_LEN, val: 16'd0};
      tbl_raddr = idx_ff[TAW-1:0];
      hist_we   = 1'b0;
      hist_clr  = 1'b0;
      hist_wa   = len_q;
      hist_wd   = hist_ff[len_q] + HW'(1);
      nc_we     = 1'b0;
      nc_clr    = 1'b0;
      nc_wa     = len_q;
      nc_wd     = nc_ff[len_q] + 16'd1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  chtd_pkg::MODE_LOAD: begin
                     len_we       = (10'(req_data.symbol_index) < 10'(MAX_SYMBOLS));
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: chtd_pkg::STATUS_OK, symbol: 9'd0,
                                      bits_used: 4'd0};
                  end
                  chtd_pkg::MODE_BUILD: begin
                     hist_clr   = 1'b1;
                     nc_clr     = 1'b1;
                     idx_in     = '0;
                     kraft_in   = '0;
                     present_in = '0;
                     nc_run_in  = '0;
                     hprev_in   = '0;
                     state_in   = ST_CLR;
                  end
                  chtd_pkg::MODE_DECODE: begin
                     if (!ready_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: chtd_pkg::STATUS_BAD_SYMBOL, symbol: 9'd0,
                                   bits_used: 4'd0};
                     end else begin
                        tbl_raddr = TAW'(req_data.bit_window[HB-1:0]);
                        win_in    = req_data.bit_window;
                        state_in  = ST_DEC_R;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: chtd_pkg::STATUS_OK, symbol: 9'd0,
                                      bits_used: 4'd0};
                  end
               endcase
            end
         end

         ST_CLR: begin
            tbl_we    = (idx_ff < CW'(TABLE_DEPTH));
            pfx_we    = (idx_ff < CW'(HEAD));
            if (idx_ff == CLR_LAST) begin
               idx_in   = '0;
               state_in = ST_CNT;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         ST_CNT: begin
            if (idx_ff < n_cnt) begin
               pv_in  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (pv_ff) begin
               if (len_q > 4'(MAX_CODE_LENGTH)) begin
                  ready_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                             bits_used: 4'd0};
                  state_in = ST_IDLE;
               end else begin
                  hist_we = 1'b1;
               end
            end else if (idx_ff >= n_cnt) begin
               idx_in   = CW'(1);
               state_in = ST_KRF;
            end
         end

         ST_KRF: begin
            kraft_in   = kraft_sum;
            present_in = present_sum;
            nc_we      = 1'b1;
            nc_wa      = krf_l;
            nc_wd      = nc_gen;
            nc_run_in  = nc_gen;
            hprev_in   = hist_ff[krf_l];
            idx_in     = idx_ff + CW'(1);
            if (krf_l == 4'(MAX_CODE_LENGTH)) begin
               multi_in = (present_sum >= HW'(2));
               if (kraft_sum > KRAFT_FULL
                   || (present_sum >= HW'(2) && kraft_sum != KRAFT_FULL)) begin
                  ready_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                             bits_used: 4'd0};
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_ASG_RD;
               end
            end
         end

         ST_ASG_RD: begin
            if (idx_ff >= n_cnt) begin
               idx_in   = '0;
               size_in  = SW'(HEAD);
               state_in = ST_SIZ;
            end else begin
               state_in = ST_ASG_LEN;
            end
         end

         ST_ASG_LEN: begin
            if (len_q == 4'd0) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_ASG_RD;
            end else begin
               rc_we  = 1'b1;
               nc_we  = 1'b1;
               len_in = len_q;
               rc_in  = rev_a;
               if ({1'b0, len_q} > 5'(ROOT_BITS)) begin
                  pfx_raddr = rev_a[HB-1:0];
                  state_in  = ST_ASG_PFX;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_ASG_RD;
               end
            end
         end

         ST_ASG_PFX: begin
            pfx_waddr = rc_ff[HB-1:0];
            pfx_wdata = len_ff;
            pfx_we    = (pfx_q < len_ff);
            idx_in    = idx_ff + CW'(1);
            state_in  = ST_ASG_RD;
         end

         ST_SIZ: begin
            if (idx_ff < CW'(HEAD)) begin
               pv_in   = 1'b1;
               prev_in = idx_ff;
               idx_in  = idx_ff + CW'(1);
            end
            if (pv_ff) begin
               if ({1'b0, pfx_q} > 5'(ROOT_BITS)) begin
                  tbl_we    = 1'b1;
                  tbl_waddr = prev_ff[TAW-1:0];
                  tbl_wdata = '{len: {1'b0, pfx_q}, val: size_ff[15:0]};
                  size_in   = size_ff + (SW'(1) << (pfx_q - 4'(ROOT_BITS)));
               end
            end else if (idx_ff >= CW'(HEAD)) begin
               if (size_ff > SW'(TABLE_DEPTH)) begin
                  ready_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                             bits_used: 4'd0};
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_FIL_RD;
               end
            end
         end

         ST_FIL_RD: begin
            if (idx_ff >= n_cnt) begin
               idx_in   = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_FIL_SYM;
            end
         end

         ST_FIL_SYM: begin
            if (len_q == 4'd0) begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_FIL_RD;
            end else begin
               len_in = len_q;
               rc_in  = 16'(rc_q);
               j_in   = '0;
               if ({1'b0, len_q} <= 5'(ROOT_BITS)) begin
                  state_in = ST_FIL_EA;
               end else begin
                  tbl_raddr = TAW'(rc_q[HB-1:0]);
                  state_in  = ST_FIL_ROOT;
               end
            end
         end

         ST_FIL_ROOT: begin
            maxl_in  = tbl_q.len;
            start_in = tbl_q.val;
            if (tbl_q.len == chtd_pkg::EMPTY_LEN || tbl_q.len < {1'b0, len_ff}
                || tbl_q.len <= 5'(ROOT_BITS)) begin
               ready_in     = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                          bits_used: 4'd0};
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FIL_EA;
            end
         end

         ST_FIL_EA: begin
            if (short_code) begin
               tbl_raddr = ea_short[TAW-1:0];
               ea_in     = ea_short[TAW-1:0];
               state_in  = ST_FIL_EW;
            end else if (ea_long >= size_ff) begin
               ready_in     = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                          bits_used: 4'd0};
               state_in = ST_IDLE;
            end else begin
               tbl_raddr = ea_long[TAW-1:0];
               ea_in     = ea_long[TAW-1:0];
               state_in  = ST_FIL_EW;
            end
         end

         ST_FIL_EW: begin
            if (tbl_q.len != chtd_pkg::EMPTY_LEN) begin
               // two codes claim the same entry
               ready_in     = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                          bits_used: 4'd0};
               state_in = ST_IDLE;
            end else begin
               tbl_we    = 1'b1;
               tbl_waddr = ea_ff;
               tbl_wdata = '{len: {1'b0, len_ff}, val: 16'(idx_ff)};
               if (j_last) begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_FIL_RD;
               end else begin
                  j_in     = j_ff + 16'd1;
                  state_in = ST_FIL_EA;
               end
            end
         end

         ST_FIN: begin
            if (SW'(idx_ff) < size_ff) begin
               pv_in   = 1'b1;
               prev_in = idx_ff;
               idx_in  = idx_ff + CW'(1);
            end
            if (pv_ff) begin
               if (tbl_q.len == chtd_pkg::EMPTY_LEN) begin
                  if (multi_ff) begin
                     ready_in     = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_in = '{status: chtd_pkg::STATUS_BAD_TREE, symbol: 9'd0,
                                bits_used: 4'd0};
                     state_in = ST_IDLE;
                  end else begin
                     // fewer than two symbols: leftover entries decode as invalid
                     tbl_we    = 1'b1;
                     tbl_waddr = prev_ff[TAW-1:0];
                     tbl_wdata = '{len: (prev_ff < CW'(HEAD)) ? 5'd1 : 5'(ROOT_BITS + 1),
                                   val: chtd_pkg::NO_SYMBOL};
                  end
               end
            end else if (SW'(idx_ff) >= size_ff) begin
               ready_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: chtd_pkg::STATUS_OK, symbol: 9'd0, bits_used: 4'd0};
               state_in = ST_IDLE;
            end
         end

         ST_DEC_R, ST_DEC_S: begin
            if (ev.bad) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: chtd_pkg::STATUS_BAD_SYMBOL, symbol: 9'd0,
                          bits_used: 4'd0};
               state_in = ST_IDLE;
            end else if (ev.chain) begin
               tbl_raddr = ev.idx2[TAW-1:0];
               state_in  = ST_DEC_S;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: chtd_pkg::STATUS_OK, symbol: tbl_q.val[8:0],
                          bits_used: tbl_q.len[3:0]};
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pv_ff        <= 1'b0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= chtd_pkg::COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         pv_ff        <= pv_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) csr_ff <= csr_wdata;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      prev_ff    <= prev_in;
      j_ff       <= j_in;
      len_ff     <= len_in;
      rc_ff      <= rc_in;
      maxl_ff    <= maxl_in;
      start_ff   <= start_in;
      ea_ff      <= ea_in;
      size_ff    <= size_in;
      kraft_ff   <= kraft_in;
      present_ff <= present_in;
      multi_ff   <= multi_in;
      nc_run_ff  <= nc_run_in;
      hprev_ff   <= hprev_in;
      win_ff     <= win_in;
      rsp_ff     <= rsp_in;
   end

   // histogram and next-code registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < 16; k++) begin
         if (hist_clr) hist_ff[k] <= '0;
         if (nc_clr)   nc_ff[k]   <= '0;
      end
      if (hist_we) hist_ff[hist_wa] <= hist_wd;
      if (nc_we)   nc_ff[nc_wa]     <= nc_wd;
   end

   // code length store
   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_waddr] <= len_wdata;
      len_q <= len_mem[idx_ff[LAW-1:0]];
   end

   // reversed code per symbol
   always_ff @(posedge clock) begin
      if (rc_we) rc_mem[idx_ff[LAW-1:0]] <= rev_a[MAX_CODE_LENGTH-1:0];
      rc_q <= rc_mem[idx_ff[LAW-1:0]];
   end

   // longest code length under each root prefix
   always_ff @(posedge clock) begin
      if (pfx_we) pfx_mem[pfx_waddr] <= pfx_wdata;
      pfx_q <= pfx_mem[pfx_raddr];
   end

   // two-level lookup table
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tbl_q <= tbl_mem[tbl_raddr];
   end

   // decode while the table is not ready reports an invalid symbol next cycle
   a_dec_not_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == chtd_pkg::MODE_DECODE && !ready_ff)
      |=> (rsp_valid && rsp_data.status == chtd_pkg::STATUS_BAD_SYMBOL))
      else $error("decode without table did not report invalid symbol");

   // failed results carry no symbol
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != chtd_pkg::STATUS_OK)
      |-> (rsp_data.symbol == 9'd0 && rsp_data.bits_used == 4'd0))
      else $error("failed result carries symbol data");

   // table becomes ready only with a good build result
   a_ready_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> (rsp_valid && rsp_data.status == chtd_pkg::STATUS_OK))
      else $error("table ready without build result");

   // fill writes stay inside the built table
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIL_EW && tbl_we) |-> (SW'(ea_ff) < size_ff))
      else $error("fill write beyond table size");

endmodule

// ===== src/chtd_lookup.sv =====
// ----------------------------------------------------------------------------
// chtd_lookup
// Classifies one table entry during a decode: final, chained or invalid.
// ----------------------------------------------------------------------------
module chtd_lookup #(
   parameter int ROOT_BITS       = 9,
   parameter int MAX_CODE_LENGTH = 15,
   parameter int MAX_SYMBOLS     = 288,
   parameter int TABLE_DEPTH     = 1024
) (
   input  chtd_pkg::entry_type  entry,
   input  logic [14:0]          window,
   input  logic                 second,
   output chtd_pkg::lookup_type result
);

   logic [4:0]  extra;
   logic [16:0] mask;
   logic [16:0] offset;

   always_comb begin
      extra  = entry.len - 5'(ROOT_BITS);
      mask   = (17'd1 << extra) - 17'd1;
      offset = (17'(window) >> ROOT_BITS) & mask;
      result.idx2  = 17'(entry.val) + offset;
      result.chain = 1'b0;
      result.bad   = 1'b0;
      if (entry.len > 5'(MAX_CODE_LENGTH)) begin
         result.bad = 1'b1;
      end else if (!second && entry.len > 5'(ROOT_BITS)) begin
         // root entry points at a sub-table
         result.chain = 1'b1;
         result.bad   = result.idx2 >= 17'(TABLE_DEPTH);
      end else begin
         result.bad = (entry.val >= 16'(MAX_SYMBOLS)) || (entry.len == 5'd0);
      end
   end

endmodule

// ===== bench/tb_canonical_huffman_table_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_canonical_huffman_table_decoder
// Loads code lengths, builds tables and decodes bit windows. A scoreboard keeps
// its own copy of the length store and the two-level table and predicts every
// result. Directed set-ups cover the corner cases, then random codes follow.
// ----------------------------------------------------------------------------
module tb_canonical_huffman_table_decoder;

   localparam int ROOT = 9;
   localparam int MAXLEN = 15;
   localparam int NSYM = 288;
   localparam int DEPTH = 1024;
   localparam int HEAD = 1 << ROOT;
   localparam int UNUSED = 16;
   localparam int TARGET_ITEMS = 1400;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the length store and lookup table
   // -------------------------------------------------------------------------
   class huff_scoreboard;
      int lengths[NSYM];
      int tab_len[DEPTH];
      int tab_val[DEPTH];
      bit ready;
      int sym_count;
      chtd_pkg::rsp_type pending[$];
      int errors;

      function new();
         foreach (lengths[i]) lengths[i] = 0;
         foreach (tab_len[i]) begin
            tab_len[i] = UNUSED;
            tab_val[i] = 0;
         end
         ready = 0;
         sym_count = 288;
         errors = 0;
      endfunction

      function int reverse(int v, int n);
         int r;
         r = 0;
         for (int k = 0; k < n; k++) r |= ((v >> (n - 1 - k)) & 1) << k;
         return r;
      endfunction

      function void set_count(logic [8:0] v);
         sym_count = v;
      endfunction

      // canonical build; returns 1 on a usable table
      function bit build_table();
         int n, kraft, present, size, ptr, l, r, cnt, idx, maxl, base, idx2;
         int hist[16];
         int nxt[16];
         int pml[HEAD];
         int code[NSYM];
         n = (sym_count > NSYM) ? NSYM : sym_count;
         kraft = 0;
         present = 0;
         foreach (hist[i]) begin
            hist[i] = 0;
            nxt[i] = 0;
         end
         foreach (pml[i]) pml[i] = 0;
         foreach (code[i]) code[i] = 0;
         foreach (tab_len[i]) begin
            tab_len[i] = UNUSED;
            tab_val[i] = 0;
         end
         for (int i = 0; i < n; i++) hist[lengths[i]]++;
         hist[0] = 0;
         for (int k = 1; k <= MAXLEN; k++) begin
            kraft += hist[k] << (MAXLEN - k);
            present += hist[k];
         end
         if (kraft > (1 << MAXLEN)) return 0;
         if (present >= 2 && kraft != (1 << MAXLEN)) return 0;
         for (int k = 1; k <= MAXLEN; k++) nxt[k] = ((nxt[k-1] + hist[k-1]) << 1) & 16'hFFFF;
         for (int i = 0; i < n; i++) begin
            l = lengths[i];
            if (l == 0) continue;
            code[i] = nxt[l] & ((1 << l) - 1);
            nxt[l] = (nxt[l] + 1) & 16'hFFFF;
         end
         for (int i = 0; i < n; i++) begin
            l = lengths[i];
            if (l <= ROOT) continue;
            idx = reverse(code[i] >> (l - ROOT), ROOT);
            if (pml[idx] < l) pml[idx] = l;
         end
         size = HEAD;
         for (int i = 0; i < HEAD; i++)
            if (pml[i] > ROOT) size += 1 << (pml[i] - ROOT);
         if (size > DEPTH) return 0;
         ptr = HEAD;
         for (int i = 0; i < HEAD; i++) begin
            if (pml[i] <= ROOT) continue;
            tab_len[i] = pml[i];
            tab_val[i] = ptr;
            ptr += 1 << (pml[i] - ROOT);
         end
         for (int i = 0; i < n; i++) begin
            l = lengths[i];
            if (l == 0) continue;
            r = reverse(code[i], l);
            if (l <= ROOT) begin
               cnt = 1 << (ROOT - l);
               for (int j = 0; j < cnt; j++) begin
                  idx = r | (j << l);
                  if (tab_len[idx] != UNUSED) return 0;
                  tab_len[idx] = l;
                  tab_val[idx] = i;
               end
            end else begin
               idx = r & (HEAD - 1);
               maxl = tab_len[idx];
               base = tab_val[idx];
               if (maxl == UNUSED || maxl < l || maxl <= ROOT) return 0;
               cnt = 1 << (maxl - l);
               for (int j = 0; j < cnt; j++) begin
                  idx2 = base + ((r >> ROOT) | (j << (l - ROOT)));
                  if (idx2 >= size || tab_len[idx2] != UNUSED) return 0;
                  tab_len[idx2] = l;
                  tab_val[idx2] = i;
               end
            end
         end
         // leftover slots are only legal for a zero or one symbol alphabet
         for (int i = 0; i < size; i++) begin
            if (tab_len[i] != UNUSED) continue;
            if (present >= 2) return 0;
            tab_len[i] = (i < HEAD) ? 1 : ROOT + 1;
            tab_val[i] = 16'hFFFF;
         end
         return 1;
      endfunction

      function bit lookup(int win, output int sym, output int used);
         int len, val, extra, idx2;
         sym = 0;
         used = 0;
         len = tab_len[win & (HEAD - 1)];
         val = tab_val[win & (HEAD - 1)];
         if (len > MAXLEN) return 0;
         if (len > ROOT) begin
            extra = len - ROOT;
            idx2 = val + ((win >> ROOT) & ((1 << extra) - 1));
            if (idx2 >= DEPTH) return 0;
            len = tab_len[idx2];
            val = tab_val[idx2];
            if (len > MAXLEN) return 0;
         end
         if (val >= NSYM || len == 0) return 0;
         sym = val;
         used = len;
         return 1;
      endfunction

      // called once per transferred request
      function void note_request(chtd_pkg::req_type q);
         chtd_pkg::rsp_type e;
         int sym, used;
         e = '0;
         case (q.mode)
            chtd_pkg::MODE_LOAD: begin
               if (q.symbol_index < NSYM) lengths[q.symbol_index] = q.code_length;
            end
            chtd_pkg::MODE_BUILD: begin
               ready = build_table();
               e.status = ready ? chtd_pkg::STATUS_OK : chtd_pkg::STATUS_BAD_TREE;
            end
            chtd_pkg::MODE_DECODE: begin
               if (ready && lookup(q.bit_window, sym, used)) begin
                  e.symbol = 9'(sym);
                  e.bits_used = 4'(used);
               end else begin
                  e.status = chtd_pkg::STATUS_BAD_SYMBOL;
               end
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      function void check_response(chtd_pkg::rsp_type a);
         chtd_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.symbol !== e.symbol) begin
            $error("symbol: expected %0d, got %0d", e.symbol, a.symbol);
            errors++;
         end
         if (a.bits_used !== e.bits_used) begin
            $error("bits_used: expected %0d, got %0d", e.bits_used, a.bits_used);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and clocking
   // -------------------------------------------------------------------------
   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   chtd_pkg::req_type req_data = '0;
   logic rsp_valid;
   chtd_pkg::rsp_type rsp_data;
   logic csr_we = 0;
   logic [8:0] csr_wdata = '0;

   huff_scoreboard sb = new();
   int items = 0;
   int burst_left = 0;
   int code_len[NSYM];

   always #5 clock = ~clock;

   canonical_huffman_table_decoder u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // results are one-cycle strobes; nothing can hold them off
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Drivers; every task starts and ends on a falling edge
   // -------------------------------------------------------------------------
   task automatic send(input logic [1:0] mode, input int sidx, input int clen, input int win);
      chtd_pkg::req_type q;
      int gap;
      q.mode = mode;
      q.symbol_index = 9'(sidx);
      q.code_length = 4'(clen);
      q.bit_window = 15'(win);
      // bursts with random gaps; about a third of bursts follow with no gap
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      start <= 1;
      req_data <= q;
      // busy only moves on a rising edge, so its value here holds through the next one
      while (busy) @(negedge clock);
      sb.note_request(q);
      items++;
      @(negedge clock);
   endtask

   // drop start and wait until every result is back and the block is quiet
   task automatic drain();
      start <= 0;
      burst_left = 0;
      @(negedge clock);
      while (sb.pending.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(input logic [8:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      sb.set_count(v);
   endtask

   task automatic load_lengths(input int n_eff);
      for (int i = 0; i < n_eff; i++) send(chtd_pkg::MODE_LOAD, i, code_len[i], $urandom);
   endtask

   task automatic decode_some(input int cnt);
      int pick;
      for (int i = 0; i < cnt; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) send(chtd_pkg::MODE_DECODE, $urandom, $urandom, 0);
         else if (pick == 1) send(chtd_pkg::MODE_DECODE, $urandom, $urandom, 15'h7FFF);
         else if (pick == 2) send(chtd_pkg::MODE_NONE, $urandom, $urandom, $urandom);
         // a load in the middle of decoding leaves the table alone
         else if (pick == 3)
            send(chtd_pkg::MODE_LOAD, $urandom_range(0, 511), $urandom, $urandom);
         else send(chtd_pkg::MODE_DECODE, $urandom, $urandom, $urandom);
      end
   endtask

   // prefix code with k leaves (complete for k of two or more) spread over the first n_eff symbols
   function automatic void make_code(input int n_eff, input int k, input bit deep);
      int lv[$];
      int j, tries, t;
      int pos[NSYM];
      foreach (code_len[i]) code_len[i] = 0;
      if (k == 1) lv.push_back($urandom_range(1, MAXLEN));
      if (k >= 2) lv = '{1, 1};
      while (lv.size() < k) begin
         j = deep ? lv.size() - 1 : $urandom_range(0, lv.size() - 1);
         tries = 0;
         while (lv[j] >= MAXLEN && tries < 64) begin
            j = $urandom_range(0, lv.size() - 1);
            tries++;
         end
         if (lv[j] >= MAXLEN) break;
         t = lv[j] + 1;
         lv.delete(j);
         lv.push_back(t);
         lv.push_back(t);
      end
      for (int i = 0; i < n_eff; i++) pos[i] = i;
      for (int i = n_eff - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = pos[i];
         pos[i] = pos[j];
         pos[j] = t;
      end
      foreach (lv[i]) code_len[pos[i]] = lv[i];
   endfunction

   task automatic run_phase(input logic [8:0] count, input bit well_formed, input bit deep,
                            input int decodes);
      int n_eff, kmax;
      n_eff = (count > NSYM) ? NSYM : count;
      kmax = (n_eff > 60) ? 60 : n_eff;
      if (well_formed) begin
         make_code(n_eff, $urandom_range(0, kmax), deep);
      end else begin
         foreach (code_len[i])
            code_len[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAXLEN);
      end
      write_count(count);
      load_lengths(n_eff);
      send(chtd_pkg::MODE_BUILD, $urandom, $urandom, $urandom);
      decode_some(decodes);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int nraw, sel;
      int head_len[8];
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // no table yet, unknown mode, loads past the alphabet
      send(chtd_pkg::MODE_DECODE, 0, 0, 15'h5A5A);
      send(chtd_pkg::MODE_NONE, 9'h1FF, 4'hF, 15'h7FFF);
      send(chtd_pkg::MODE_LOAD, 300, 15, 0);
      send(chtd_pkg::MODE_LOAD, 511, 7, 0);
      // fill every length entry once so no build reads an unwritten one
      foreach (code_len[i]) code_len[i] = 0;
      load_lengths(NSYM);

      // empty alphabet, then a lone symbol
      write_count(9'd0);
      send(chtd_pkg::MODE_BUILD, 0, 0, 0);
      send(chtd_pkg::MODE_DECODE, 0, 0, 0);
      write_count(9'd1);
      send(chtd_pkg::MODE_LOAD, 0, 1, 0);
      send(chtd_pkg::MODE_BUILD, 0, 0, 0);
      send(chtd_pkg::MODE_DECODE, 0, 0, 0);
      send(chtd_pkg::MODE_DECODE, 0, 0, 15'h7FFF);

      // oversubscribed, then incomplete; the failed build kills decoding
      write_count(9'd3);
      send(chtd_pkg::MODE_LOAD, 1, 1, 0);
      send(chtd_pkg::MODE_LOAD, 2, 1, 0);
      send(chtd_pkg::MODE_BUILD, 0, 0, 0);
      send(chtd_pkg::MODE_DECODE, 0, 0, 15'h0001);
      write_count(9'd2);
      send(chtd_pkg::MODE_LOAD, 1, 2, 0);
      send(chtd_pkg::MODE_BUILD, 0, 0, 0);
      send(chtd_pkg::MODE_DECODE, 0, 0, 0);

      // nine root prefixes reaching length 15 need more sub-table than fits
      foreach (code_len[i]) code_len[i] = 0;
      head_len = '{1, 2, 3, 4, 5, 7, 8, 9};
      for (int i = 0; i < 8; i++) code_len[i] = head_len[i];
      for (int p = 0; p < 9; p++)
         for (int d = 0; d < 7; d++) code_len[8 + 7 * p + d] = (d == 6) ? 15 : 10 + d;
      write_count(9'd71);
      load_lengths(71);
      send(chtd_pkg::MODE_BUILD, 0, 0, 0);
      decode_some(4);

      // count above the alphabet saturates; then the full alphabet
      run_phase(9'h1FF, 1, 1, 20);
      run_phase(9'd288, 1, 0, 20);

      // random codes: mostly complete, some deep, some garbage
      while (items < TARGET_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) nraw = $urandom_range(289, 511);
         else if (sel < 4) nraw = $urandom_range(41, 288);
         else nraw = $urandom_range(1, 40);
         run_phase(9'(nraw), $urandom_range(0, 6) != 0, $urandom_range(0, 2) == 0,
                   $urandom_range(5, 30));
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
